FILE: rtl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg
// Types and codes shared by the LSB stego payload extractor.
// ----------------------------------------------------------------------------
package lspe_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_LEN    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_LOW    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_HIGH   = 2'd3;

  localparam logic [15:0] HEADER_BYTES_RST = 16'd54;

  typedef enum logic [1:0] {
    KIND_EXT      = 2'd0,
    KIND_PAY      = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      out_kind;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] header_bytes;
    logic [3:0]  magic_len;
    logic [63:0] magic_low;
    logic [15:0] magic_high;
  } cfg_t;

endpackage

FILE: rtl/lspe_cfg_regs.sv
// ----------------------------------------------------------------------------
// lspe_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module lspe_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lspe_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lspe_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output lspe_pkg::cfg_t                    cfg_o
);
  import lspe_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_BYTES: cfg_d.header_bytes = cfg_wdata_i[15:0];
        CFG_MAGIC_LEN:    cfg_d.magic_len    = cfg_wdata_i[3:0];
        CFG_MAGIC_LOW:    cfg_d.magic_low    = cfg_wdata_i;
        CFG_MAGIC_HIGH:   cfg_d.magic_high   = cfg_wdata_i[15:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes <= HEADER_BYTES_RST;
      cfg_q.magic_len    <= '0;
      cfg_q.magic_low    <= '0;
      cfg_q.magic_high   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/lspe_core.sv
// ----------------------------------------------------------------------------
// lspe_core
// Decoder state and per-item decode: header skip, bit collection, field
// handling and magic check.
// ----------------------------------------------------------------------------
module lspe_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lspe_pkg::in_item_t  item_i,
  input  lspe_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output lspe_pkg::out_item_t res_o
);
  import lspe_pkg::*;

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_MAGIC_LEN = 3'd1;
  localparam logic [2:0] PH_MAGIC     = 3'd2;
  localparam logic [2:0] PH_EXT_LEN   = 3'd3;
  localparam logic [2:0] PH_EXT       = 3'd4;
  localparam logic [2:0] PH_PAY_LEN   = 3'd5;
  localparam logic [2:0] PH_PAY       = 3'd6;
  localparam logic [2:0] PH_IDLE      = 3'd7;

  logic [2:0]  phase_q, phase_d, cur_phase, work_phase;
  logic [15:0] hcnt_q, hcnt_d, cur_hcnt;
  logic [4:0]  bidx_q, bidx_d, cur_bidx;
  logic [31:0] shift_q, shift_d, cur_shift, shifted;
  logic [31:0] rem_q, rem_d, cur_rem, rem_dec;
  logic [3:0]  midx_q, midx_d, cur_midx;
  logic        len_field;
  logic [15:0][7:0] magic_bytes;

  assign magic_bytes = {48'h0, cfg_i.magic_high, cfg_i.magic_low};

  // start of file acts on the state seen by this item
  assign cur_phase = item_i.start_of_file ? PH_HEADER : phase_q;
  assign cur_hcnt  = item_i.start_of_file ? 16'd0     : hcnt_q;
  assign cur_bidx  = item_i.start_of_file ? 5'd0      : bidx_q;
  assign cur_shift = item_i.start_of_file ? 32'd0     : shift_q;
  assign cur_rem   = item_i.start_of_file ? 32'd0     : rem_q;
  assign cur_midx  = item_i.start_of_file ? 4'd0      : midx_q;

  assign work_phase = (cur_phase == PH_HEADER) ? PH_MAGIC_LEN : cur_phase;
  assign len_field  = (work_phase == PH_MAGIC_LEN) || (work_phase == PH_EXT_LEN) ||
                      (work_phase == PH_PAY_LEN);
  assign shifted    = cur_shift | (32'(item_i.carrier_byte[0]) << cur_bidx);
  assign rem_dec    = cur_rem - 32'd1;

  always_comb begin
    phase_d     = cur_phase;
    hcnt_d      = cur_hcnt;
    bidx_d      = cur_bidx;
    shift_d     = cur_shift;
    rem_d       = cur_rem;
    midx_d      = cur_midx;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'd0, out_kind: KIND_EXT, is_last: 1'b0};

    if (cur_phase == PH_HEADER && cur_hcnt < cfg_i.header_bytes) begin
      hcnt_d = cur_hcnt + 16'd1;
    end else if (work_phase != PH_IDLE) begin
      phase_d = work_phase;
      if (cur_bidx != (len_field ? 5'd31 : 5'd7)) begin
        bidx_d  = cur_bidx + 5'd1;
        shift_d = shifted;
      end else begin
        bidx_d  = '0;
        shift_d = '0;
        unique case (work_phase)
          PH_MAGIC_LEN: begin
            if (shifted != 32'(cfg_i.magic_len)) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o       = '{out_byte: 8'd0, out_kind: KIND_MISMATCH, is_last: 1'b1};
            end else if (shifted == 32'd0) begin
              phase_d = PH_EXT_LEN;
            end else begin
              phase_d = PH_MAGIC;
              rem_d   = shifted;
              midx_d  = '0;
            end
          end
          PH_MAGIC: begin
            if (shifted[7:0] != magic_bytes[cur_midx]) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o       = '{out_byte: 8'd0, out_kind: KIND_MISMATCH, is_last: 1'b1};
            end else begin
              midx_d = cur_midx + 4'd1;
              rem_d  = rem_dec;
              if (rem_dec == 32'd0) phase_d = PH_EXT_LEN;
            end
          end
          PH_EXT_LEN: begin
            if (shifted == 32'd0) begin
              phase_d = PH_PAY_LEN;
            end else begin
              phase_d = PH_EXT;
              rem_d   = shifted;
            end
          end
          PH_EXT: begin
            rem_d       = rem_dec;
            if (rem_dec == 32'd0) phase_d = PH_PAY_LEN;
            res_valid_o = 1'b1;
            res_o       = '{out_byte: shifted[7:0], out_kind: KIND_EXT, is_last: 1'b0};
          end
          PH_PAY_LEN: begin
            if (shifted == 32'd0) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o       = '{out_byte: 8'd0, out_kind: KIND_EMPTY, is_last: 1'b1};
            end else begin
              phase_d = PH_PAY;
              rem_d   = shifted;
            end
          end
          PH_PAY: begin
            rem_d       = rem_dec;
            res_valid_o = 1'b1;
            res_o       = '{out_byte: shifted[7:0], out_kind: KIND_PAY,
                            is_last: (rem_dec == 32'd0)};
            if (rem_dec == 32'd0) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= '0;
      bidx_q  <= '0;
      shift_q <= '0;
      rem_q   <= '0;
      midx_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      bidx_q  <= bidx_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      midx_q  <= midx_d;
    end
  end

endmodule

FILE: rtl/lsb_stego_payload_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor
// Pulls a hidden extension and payload out of the LSBs of image file bytes.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register, and the decode logic feeds
// straight into the result register. Throughput: one item per cycle while
// the output is not stalled.
// Reset: decoder back to header skip, all config registers to reset values.
// ----------------------------------------------------------------------------
module lsb_stego_payload_extractor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lspe_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lspe_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lspe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lspe_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lspe_pkg::*;

  cfg_t      cfg;
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      advance, accept, res_valid;
  out_item_t res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  lspe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lspe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)       in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)                          out_valid_d = res_valid;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept)               in_item_q  <= in_data_i;
    if (advance && res_valid) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_kind == KIND_MISMATCH ||
                    out_data_o.out_kind == KIND_EMPTY)
    |-> (out_data_o.is_last && out_data_o.out_byte == 8'd0))
    else $error("status item with data or without last");

  a_ext_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_EXT |-> !out_data_o.is_last)
    else $error("extension character marked last");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(in_valid_q))
    else $error("result without an item in the input register");

endmodule
